// File: rtl/core/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg: shared types and constants for the radix digit converter
// Widths, the division step geometry, the interface structs between the
// sequencer and the divider, and the digit helper functions.
// ----------------------------------------------------------------------------
package itrd_pkg;

	// Width of the value that is converted (low bits of the input field).
	localparam int VALUE_WIDTH = 32;
	// Width of the input field on the port.
	localparam int IN_WIDTH    = 32;
	// Largest number of digits kept for one value.
	localparam int MAX_DIGITS  = 32;

	// Quotient bits retired by the divider in one cycle.
	localparam int DIV_BITS    = 8;
	localparam int DIV_STEPS   = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_WIDTH   = DIV_STEPS * DIV_BITS;
	localparam int STEP_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W      = $clog2(MAX_DIGITS);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0]  ASCII_A     = CHAR_W'(65);

	// Mask that keeps the low VALUE_WIDTH bits of the input field.
	localparam logic [IN_WIDTH-1:0] VALUE_MASK =
		(VALUE_WIDTH >= IN_WIDTH) ? {IN_WIDTH{1'b1}} :
		IN_WIDTH'((64'd1 << VALUE_WIDTH) - 64'd1);

	// Request from the sequencer to the divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_WIDTH-1:0] dividend;
		logic [RADIX_W-1:0]   radix;
	} div_ctrl_t;

	// Result of one division.
	typedef struct packed {
		logic                 done;
		logic [DIV_WIDTH-1:0] quotient;
		logic [DIGIT_W-1:0]   remainder;
	} div_stat_t;

	// Clamp the programmed radix into the legal range.
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) res = RADIX_MIN;
		if (r > RADIX_MAX) res = RADIX_MAX;
		return res;
	endfunction

	// Map a digit value onto its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < DECIMAL_DIGITS) begin
			res = ASCII_ZERO + CHAR_W'(d);
		end else begin
			res = ASCII_A + CHAR_W'(d - DECIMAL_DIGITS);
		end
		return res;
	endfunction

endpackage

// File: rtl/core/itrd_div_unit.sv
// ----------------------------------------------------------------------------
// itrd_div_unit: iterative divider by a small radix
// Restoring division of the working quotient by the radix, retiring
// DIV_BITS quotient bits per cycle, with the remainder kept below 36.
// ----------------------------------------------------------------------------
module itrd_div_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  itrd_pkg::div_ctrl_t ctrl,
	output itrd_pkg::div_stat_t stat
);
	import itrd_pkg::*;

	logic [DIV_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [STEP_W-1:0]    step_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_BITS-1:0]  top_bits;
	logic [DIV_BITS-1:0]  qbits;
	logic [DIGIT_W-1:0]   rem_n;

	// One cycle of the divider: DIV_BITS compare-and-subtract steps.
	always_comb begin
		logic [DIGIT_W:0] part;
		logic [DIGIT_W-1:0] acc;
		top_bits = quo_q[DIV_WIDTH-1 -: DIV_BITS];
		acc = rem_q;
		qbits = '0;
		for (int i = DIV_BITS - 1; i >= 0; i--) begin
			part = {acc, top_bits[i]};
			if (part >= {1'b0, radix_q}) begin
				part = part - {1'b0, radix_q};
				qbits[i] = 1'b1;
			end
			acc = part[DIGIT_W-1:0];
		end
		rem_n = acc;
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Working quotient and partial remainder.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q   <= ctrl.dividend;
			rem_q   <= '0;
			radix_q <= ctrl.radix;
		end else if (busy_q) begin
			quo_q <= (quo_q << DIV_BITS) | DIV_WIDTH'(qbits);
			rem_q <= rem_n;
		end
	end

	assign stat.done      = done_q;
	assign stat.quotient  = quo_q;
	assign stat.remainder = rem_q;

endmodule

// File: rtl/core/itrd_digit_ram.sv
// ----------------------------------------------------------------------------
// itrd_digit_ram: digit store
// One write port and one read port with registered read data, holding the
// remainders of the current value, least significant first.
// ----------------------------------------------------------------------------
module itrd_digit_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [itrd_pkg::ADDR_W-1:0]  waddr,
	input  logic [itrd_pkg::DIGIT_W-1:0] wdata,
	input  logic                         re,
	input  logic [itrd_pkg::ADDR_W-1:0]  raddr,
	output logic [itrd_pkg::DIGIT_W-1:0] rdata
);
	import itrd_pkg::*;

	logic [DIGIT_W-1:0] mem [MAX_DIGITS];
	logic [DIGIT_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits: unsigned integer to ASCII digits in base 2..36
// Converts one value per request into its digits, most significant first,
// flagging the final digit.
// ----------------------------------------------------------------------------
// The block takes one 32-bit value per request and returns one request per
// digit, most significant first, as ASCII '0'-'9' then 'A'-'Z', with
// last_digit set on the least significant digit; zero gives the single digit
// '0'. The radix register (reset 10) saturates to 2..36 and must only be
// written while the block is idle. Every digit costs one division in the
// shared divider, which retires 8 quotient bits per cycle. Each digit is
// then read back through the registered digit store read port and loaded
// into the output register as soon as that register is free or emptying.
// in_ready is high only while the sequencer is idle; the last digit may still
// wait in the output register when the next value is taken.
// ----------------------------------------------------------------------------
module integer_to_radix_digits (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          radix_we,
	input  logic [itrd_pkg::RADIX_W-1:0]  radix_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [itrd_pkg::IN_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [itrd_pkg::CHAR_W-1:0]   digit_char,
	output logic                          last_digit
);
	import itrd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_READ = 4'b0100,
		S_SEND = 4'b1000
	} state_t;

	state_t             state_q;
	logic [RADIX_W-1:0] radix_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  idx_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	div_ctrl_t          div_ctrl;
	div_stat_t          div_stat;
	logic [CNT_W-1:0]   cnt_next;
	logic               div_final;
	logic               ram_we;
	logic               ram_re;
	logic [DIGIT_W-1:0] ram_rdata;
	logic               in_take;
	logic               out_free;
	logic               out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = (state_q == S_SEND) && out_free;
	assign cnt_next  = cnt_q + CNT_W'(1);
	assign div_final = (div_stat.quotient == '0) || (cnt_next == CNT_W'(MAX_DIGITS));
	assign ram_we    = (state_q == S_DIV) && div_stat.done;
	assign ram_re    = (state_q == S_READ);

	// Divider requests: a new value, or the next division of the quotient.
	always_comb begin
		div_ctrl.radix    = eff_radix(radix_q);
		div_ctrl.start    = 1'b0;
		div_ctrl.dividend = DIV_WIDTH'(value & VALUE_MASK);
		if (in_take) begin
			div_ctrl.start = 1'b1;
		end else if (ram_we && !div_final) begin
			div_ctrl.start    = 1'b1;
			div_ctrl.dividend = div_stat.quotient;
		end
	end

	itrd_div_unit u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.stat   (div_stat)
	);

	itrd_digit_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (div_stat.remainder),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	// Sequencer: divide until the quotient is zero or MAX_DIGITS digits are stored, then read digits back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						cnt_q <= cnt_next;
						if (div_final) begin
							idx_q   <= cnt_q[ADDR_W-1:0];
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (out_free) begin
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - ADDR_W'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= digit_to_ascii(ram_rdata);
			out_last_q <= (idx_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = out_char_q;
	assign last_digit = out_last_q;

endmodule
